// ===== hw/rtl/page_allocator_with_refcounts_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Clocked implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNTS_UNIT_ASSERT_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNTS_UNIT_ASSERT_SVH

// same-cycle implication
`define PRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// Page allocator package
// Field widths, operation and status codes, and the update control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    localparam int NUM_PAGES_DEF  = 16384;
    localparam int COUNT_BITS_DEF = 8;

    localparam int PAGE_W   = 14;
    localparam int COUNT_W  = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [PAGE_W-1:0]   page_t;

    localparam op_t OP_ALLOC     = 3'd0;
    localparam op_t OP_FREE      = 3'd1;
    localparam op_t OP_INIT_FREE = 3'd2;
    localparam op_t OP_INC       = 3'd3;
    localparam op_t OP_DEC       = 3'd4;
    localparam op_t OP_READ      = 3'd5;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_OOM   = 3'd1;
    localparam status_t ST_RANGE = 3'd2;
    localparam status_t ST_COUNT = 3'd3;
    localparam status_t ST_FULL  = 3'd4;

    typedef struct packed {
        logic    cnt_we;
        logic    cnt_at_popped;
        logic    pop;
        logic    push;
        logic    returned;
        status_t status;
    } upd_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pra_ram.sv =====
// ----------------------------------------------------------------------------
// Page allocator RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pra_update.sv =====
// ----------------------------------------------------------------------------
// Page allocator update logic
// Works out the new count, stack action and status from the memory read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_update #(
    parameter int NUM_PAGES  = pra_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pra_pkg::COUNT_BITS_DEF
) (
    input  pra_pkg::op_t                   op,
    input  logic                           in_range,
    input  logic [COUNT_BITS-1:0]          cnt_rd,
    input  logic [$clog2(NUM_PAGES+1)-1:0] level,
    input  pra_pkg::page_t                 page,
    input  pra_pkg::page_t                 popped,
    output pra_pkg::upd_ctrl_t             ctrl,
    output logic [COUNT_BITS-1:0]          cnt_new,
    output pra_pkg::page_t                 page_res
);

    import pra_pkg::*;

    localparam int LW = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [LW-1:0]         LVL_FULL = LW'(NUM_PAGES);

    logic full;
    logic popped_ok;

    assign full      = (level == LVL_FULL);
    assign popped_ok = (32'(popped) < NUM_PAGES);

    always_comb
    begin
        ctrl     = '0;
        cnt_new  = '0;
        page_res = page;
        priority if (op == OP_ALLOC)
        begin
            if (level == '0)
            begin
                page_res    = '0;
                ctrl.status = ST_OOM;
            end
            else
            begin
                ctrl.pop           = 1'b1;
                ctrl.cnt_we        = popped_ok;
                ctrl.cnt_at_popped = 1'b1;
                page_res           = popped;
                cnt_new            = CNT_ONE;
            end
        end
        else if (op > OP_READ)
        begin
            ctrl.status = ST_OK;
        end
        else if (!in_range)
        begin
            ctrl.status = ST_RANGE;
        end
        else
        begin
            unique case (op)
                OP_FREE:
                begin
                    cnt_new     = (cnt_rd != '0) ? cnt_rd - CNT_ONE : '0;
                    ctrl.cnt_we = 1'b1;
                    if (cnt_new == '0)
                    begin
                        if (full)
                        begin
                            ctrl.status = ST_FULL;
                        end
                        else
                        begin
                            ctrl.push     = 1'b1;
                            ctrl.returned = 1'b1;
                        end
                    end
                end
                OP_INIT_FREE:
                begin
                    cnt_new     = '0;
                    ctrl.cnt_we = 1'b1;
                    if (full)
                    begin
                        ctrl.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.push     = 1'b1;
                        ctrl.returned = 1'b1;
                    end
                end
                OP_INC:
                begin
                    ctrl.cnt_we = 1'b1;
                    if (cnt_rd == CNT_MAX)
                    begin
                        cnt_new     = cnt_rd;
                        ctrl.status = ST_COUNT;
                    end
                    else
                    begin
                        cnt_new = cnt_rd + CNT_ONE;
                    end
                end
                OP_DEC:
                begin
                    ctrl.cnt_we = 1'b1;
                    if (cnt_rd == '0)
                    begin
                        cnt_new     = '0;
                        ctrl.status = ST_COUNT;
                    end
                    else
                    begin
                        cnt_new = cnt_rd - CNT_ONE;
                    end
                end
                default:
                begin
                    cnt_new = cnt_rd;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/page_allocator_with_refcounts_unit.sv =====
// ----------------------------------------------------------------------------
// Page allocator with reference counts
// Free pages sit on a LIFO stack in one RAM, per-page counts in another.
// Input channel in_valid/in_stall carries op and page; each transfer gives
// exactly one result on out_valid/out_stall: page_out, count,
// returned_to_pool and status. cfg_we writes lowest_page from cfg_data.
// An item is read, then written back: the transfer edge reads both RAMs, and
// the edge that leaves S_EXEC writes back and loads the output register,
// raising out_valid, as soon as no stalled result is held. No new item is
// taken before the previous one has written back to the count RAM.
// After reset the count RAM is cleared one entry a cycle, all NUM_PAGES
// entries, with in_stall held high; configuration writes are taken meanwhile.
// A stalled result holds in the output register; the next item may be
// taken, but its write-back waits until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module page_allocator_with_refcounts_unit #(
    parameter int NUM_PAGES  = pra_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pra_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  pra_pkg::page_t              cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pra_pkg::op_t                op,
    input  pra_pkg::page_t              page,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pra_pkg::page_t              page_out,
    output logic [pra_pkg::COUNT_W-1:0] count,
    output logic                        returned_to_pool,
    output pra_pkg::status_t            status
);

    import pra_pkg::*;

    localparam int AW = $clog2(NUM_PAGES);
    localparam int LW = $clog2(NUM_PAGES + 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_PAGES - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [LW-1:0]   level_reg, level_next;
    page_t           lowest_reg, lowest_next;
    logic            out_valid_reg, out_valid_next;

    op_t             op_reg;
    page_t           page_reg;
    logic            in_range_reg;
    page_t           page_out_reg;
    logic [COUNT_W-1:0] count_reg;
    logic            returned_reg;
    status_t         status_reg;

    logic            accept;
    logic            exec_go;
    logic            clearing;
    logic            in_range;

    logic            cnt_we;
    logic [AW-1:0]   cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rd;
    page_t           stack_rd;

    upd_ctrl_t       ctrl;
    logic [COUNT_BITS-1:0] cnt_new;
    page_t           page_res;

    assign clearing = (state_reg == S_CLEAR);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign in_range = (page >= lowest_reg) && (32'(page) < NUM_PAGES);

    assign cnt_we    = clearing || (exec_go && ctrl.cnt_we);
    assign cnt_waddr = clearing ? clr_addr_reg
                     : (ctrl.cnt_at_popped ? AW'(stack_rd) : AW'(page_reg));
    assign cnt_wdata = clearing ? '0 : cnt_new;

    pra_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (AW'(page)),
        .rdata (cnt_rd)
    );

    pra_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (exec_go && ctrl.push),
        .waddr (level_reg[AW-1:0]),
        .wdata (page_reg),
        .re    (accept),
        .raddr (AW'(level_reg - LW'(1))),
        .rdata (stack_rd)
    );

    pra_update #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .op       (op_reg),
        .in_range (in_range_reg),
        .cnt_rd   (cnt_rd),
        .level    (level_reg),
        .page     (page_reg),
        .popped   (stack_rd),
        .ctrl     (ctrl),
        .cnt_new  (cnt_new),
        .page_res (page_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        level_next     = level_reg;
        lowest_next    = cfg_we ? cfg_data : lowest_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (ctrl.pop)
                    begin
                        level_next = level_reg - LW'(1);
                    end
                    else if (ctrl.push)
                    begin
                        level_next = level_reg + LW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            level_reg     <= '0;
            lowest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            level_reg     <= level_next;
            lowest_reg    <= lowest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            page_reg     <= page;
            in_range_reg <= in_range;
        end
        if (exec_go)
        begin
            page_out_reg <= page_res;
            count_reg    <= COUNT_W'(cnt_new);
            returned_reg <= ctrl.returned;
            status_reg   <= ctrl.status;
        end
    end

    assign out_valid        = out_valid_reg;
    assign page_out         = page_out_reg;
    assign count            = count_reg;
    assign returned_to_pool = returned_reg;
    assign status           = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pra_checker.sv =====
// ----------------------------------------------------------------------------
// Page allocator port checker
// Timing and result consistency checks on the top level ports, bound in.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_allocator_with_refcounts_unit_assert.svh"

module pra_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input pra_pkg::page_t              page_out,
    input logic [pra_pkg::COUNT_W-1:0] count,
    input logic                        returned_to_pool,
    input pra_pkg::status_t            status
);

    import pra_pkg::*;

    `PRA_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "input taken on consecutive cycles")

    `PRA_ASSERT_NEXT(a_result_follows, in_valid && !in_stall ##1 (!out_valid || !out_stall), out_valid, "no result after input transfer")

    `PRA_ASSERT_NOW(a_oom_zero, out_valid && status == ST_OOM, page_out == '0 && count == '0, "out of memory result not cleared")

    `PRA_ASSERT_NOW(a_returned_ok, out_valid && returned_to_pool, status == ST_OK && count == '0, "returned page with bad status or count")

    `PRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(page_out) && $stable(status) && $stable(count), "stalled result changed")

endmodule

bind page_allocator_with_refcounts_unit pra_checker u_pra_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Page allocator testbench
// Drives allocate, free, initial free, increment, decrement and read
// operations, plus the unused codes, through the page allocator over
// several settings of lowest_page. A directed opening is followed by random
// mixes that favour allocate, count and free sequences on a small pool of
// pages. A shadow of the count table and free stack predicts every result,
// and the results are compared in order. The sender works in bursts, and
// the receiver stalls on changing patterns with long hold-offs.
// ----------------------------------------------------------------------------
module tb;

    import pra_pkg::*;

    localparam int  N_PAGES      = NUM_PAGES_DEF;
    localparam op_t OP_UNUSED6   = 3'd6;
    localparam op_t OP_UNUSED7   = 3'd7;
    localparam int  SETTLE       = 4;
    localparam int  LONG_HOLD    = 400;
    localparam int  REPORT_LIMIT = 10;

    typedef struct packed {
        op_t   o;
        page_t pg;
    } page_op_t;

    typedef struct packed {
        page_t              pg;
        logic [COUNT_W-1:0] cnt;
        logic               ret;
        status_t            st;
    } page_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    page_t              cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    op_t                op = OP_ALLOC;
    page_t              page = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    page_t              page_out;
    logic [COUNT_W-1:0] count;
    logic               returned_to_pool;
    status_t            status;

    // shadow of the allocator
    bit [COUNT_W-1:0] page_counts [N_PAGES];
    page_t            free_stack [N_PAGES];
    int               stack_depth = 0;
    page_t            low_page = '0;

    page_op_t     pending_ops[$];
    page_result_t due_results[$];
    int           ops_queued = 0;
    int           mismatches = 0;
    logic         in_acc = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_ask = 0;
    int hold_done = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_tick = 0;

    page_allocator_with_refcounts_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .page             (page),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .page_out         (page_out),
        .count            (count),
        .returned_to_pool (returned_to_pool),
        .status           (status)
    );

    always #2 clk = ~clk;

    function automatic page_result_t predict_page_op(op_t o, page_t p);
        page_result_t       r;
        logic [COUNT_W-1:0] c;
        logic               want_push;
        r = '{pg: p, cnt: '0, ret: 1'b0, st: ST_OK};
        want_push = 1'b0;
        if (o == OP_ALLOC) begin
            if (stack_depth == 0) begin
                r.pg = '0;
                r.st = ST_OOM;
            end
            else begin
                stack_depth--;
                r.pg = free_stack[stack_depth];
                page_counts[r.pg] = 1;
                r.cnt = 1;
            end
        end
        else if (o <= OP_READ) begin
            if (int'(p) < int'(low_page) || int'(p) >= N_PAGES) begin
                r.st = ST_RANGE;
            end
            else begin
                c = page_counts[p];
                case (o)
                    OP_FREE:
                    begin
                        if (c != 0)
                            c--;
                        want_push = (c == 0);
                    end
                    OP_INIT_FREE:
                    begin
                        c = '0;
                        want_push = 1'b1;
                    end
                    OP_INC:
                    begin
                        if (c == '1)
                            r.st = ST_COUNT;
                        else
                            c++;
                    end
                    OP_DEC:
                    begin
                        if (c == 0)
                            r.st = ST_COUNT;
                        else
                            c--;
                    end
                    default:
                    begin
                    end
                endcase
                page_counts[p] = c;
                if (want_push) begin
                    if (stack_depth >= N_PAGES) begin
                        r.st = ST_FULL;
                    end
                    else begin
                        free_stack[stack_depth] = p;
                        stack_depth++;
                        r.ret = 1'b1;
                    end
                end
                r.cnt = c;
            end
        end
        return r;
    endfunction

    // sender: bursts of transfers separated by random gaps
    always @(negedge clk)
    begin
        page_op_t nxt;
        if (rst_n && !(in_valid && !in_acc)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() == 0) begin
                in_valid <= 1'b0;
            end
            else begin
                nxt = pending_ops.pop_front();
                op <= nxt.o;
                page <= nxt.pg;
                in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end
                else begin
                    burst_left = $urandom_range(0, 47);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall pattern changes from stretch to stretch
    always @(negedge clk)
    begin
        logic s;
        stall_tick++;
        if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (stall_mode)
                0: s = 1'b0;
                1: s = ($urandom_range(0, 9) < 3);
                2: s = ($urandom_range(0, 9) < 7);
                default: s = ((stall_tick % 5) < 2);
            endcase
            out_stall <= s;
        end
    end

    always @(posedge clk)
    begin
        page_result_t got;
        page_result_t want;
        in_acc <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            due_results.push_back(predict_page_op(op, page));
        if (rst_n && out_valid && !out_stall) begin
            got = '{pg: page_out, cnt: count, ret: returned_to_pool, st: status};
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected transfer: page_out %0d count %0d ret %0b status %0d",
                             got.pg, got.cnt, got.ret, got.st);
            end
            else begin
                want = due_results.pop_front();
                if (got.pg !== want.pg || got.cnt !== want.cnt ||
                    got.ret !== want.ret || got.st !== want.st) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"mismatch: page_out %0d/%0d count %0d/%0d ",
                                  "ret %0b/%0b status %0d/%0d (got/expected)"},
                                 got.pg, want.pg, got.cnt, want.cnt,
                                 got.ret, want.ret, got.st, want.st);
                end
            end
        end
    end

    task automatic add_op(op_t o, page_t p);
        pending_ops.push_back('{o: o, pg: p});
        ops_queued++;
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_lowest(page_t v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        low_page = v;
    endtask

    task automatic gen_mix(int n);
        page_t pool [12];
        page_t p;
        op_t   o;
        int    goal;
        int    span;
        int    r;
        int    k;
        goal = ops_queued + n;
        span = 16383 - int'(low_page);
        if (span > 63)
            span = 63;
        foreach (pool[i])
            pool[i] = ($urandom_range(0, 7) == 0) ? page_t'($urandom)
                                                  : page_t'(low_page + $urandom_range(0, span));
        while (ops_queued < goal) begin
            p = pool[$urandom_range(0, 11)];
            r = $urandom_range(0, 99);
            if (r < 12) begin
                add_op(op_t'($urandom_range(0, 7)), page_t'($urandom));
            end
            else if (r < 72) begin
                r = $urandom_range(0, 99);
                o = (r < 25) ? OP_ALLOC : (r < 45) ? OP_FREE : (r < 55) ? OP_INIT_FREE :
                    (r < 72) ? OP_INC : (r < 89) ? OP_DEC : OP_READ;
                add_op(o, (o == OP_ALLOC) ? page_t'($urandom) : p);
            end
            else begin
                k = $urandom_range(0, 4);
                add_op(OP_ALLOC, page_t'($urandom));
                repeat (k) add_op(OP_INC, p);
                add_op(OP_READ, p);
                repeat ($urandom_range(0, k)) add_op(OP_DEC, p);
                repeat ($urandom_range(1, k + 2)) add_op(OP_FREE, p);
            end
        end
    endtask

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        set_lowest('0);
        add_op(OP_ALLOC, 0);
        add_op(OP_READ, 0);
        add_op(OP_DEC, 0);
        add_op(OP_INC, 0);
        add_op(OP_FREE, 0);
        add_op(OP_ALLOC, 16383);
        add_op(OP_FREE, 0);
        add_op(OP_FREE, 0);
        add_op(OP_INIT_FREE, 16383);
        add_op(OP_INC, 16383);
        add_op(OP_READ, 16383);
        add_op(OP_ALLOC, 14'h2AAA);
        add_op(OP_ALLOC, 14'h1555);
        add_op(OP_ALLOC, 0);
        add_op(OP_ALLOC, 16383);
        add_op(OP_UNUSED6, 16383);
        add_op(OP_UNUSED7, 14'h2AAA);
        add_op(OP_INC, 14'h1555);
        add_op(OP_INIT_FREE, 14'h1555);
        add_op(OP_READ, 14'h1555);
        add_op(OP_DEC, 16383);
        add_op(OP_DEC, 16383);
        repeat (256) add_op(OP_INC, 9);
        add_op(OP_READ, 9);
        add_op(OP_DEC, 9);
        add_op(OP_FREE, 9);
        gen_mix(300);
        drain();

        set_lowest(16383);
        add_op(OP_FREE, 0);
        add_op(OP_INC, 16382);
        add_op(OP_DEC, 14'h2000);
        add_op(OP_INIT_FREE, 16383);
        add_op(OP_READ, 16383);
        add_op(OP_ALLOC, 0);
        add_op(OP_ALLOC, 0);
        add_op(OP_UNUSED7, 5);
        hold_ask++;
        gen_mix(100);
        drain();

        set_lowest(page_t'($urandom_range(1, 16382)));
        add_op(OP_READ, page_t'(low_page - 1));
        add_op(OP_INC, low_page);
        gen_mix(300);
        drain();

        set_lowest('0);
        add_op(OP_INIT_FREE, 16383);
        add_op(OP_INC, 42);
        add_op(OP_INC, 42);
        add_op(OP_FREE, 42);
        add_op(OP_FREE, 42);
        add_op(OP_FREE, 42);
        hold_ask++;
        gen_mix(250);
        drain();

        set_lowest(page_t'($urandom_range(0, 255)));
        gen_mix(300);
        drain();

        repeat (2 * SETTLE) @(posedge clk);
        mismatches += due_results.size();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
